// ===== design/ws2812_multichannel_encoder_core_macros.svh =====
// Assertion macros used by the encoder top level.
`ifndef WS2812_MULTICHANNEL_ENCODER_CORE_MACROS_SVH
`define WS2812_MULTICHANNEL_ENCODER_CORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define WSMCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When cond holds, cons must hold in the next cycle.
`define WSMCE_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/wsmce_pkg.sv =====
// Types and constants for the multichannel WS2812 encoder.
`timescale 1ns / 1ps
package wsmce_pkg;

  localparam int DEF_CHANNELS   = 10;
  localparam int DEF_MAX_PIXELS = 256;
  localparam int BITS_PER_PIXEL = 24;

  localparam int OP_W       = 2;
  localparam int CHAN_W     = 4;
  localparam int PIXEL_W    = 8;
  localparam int COLOR_W    = 24;
  localparam int FLEN_W     = 9;
  localparam int TIMER_W    = 16;
  localparam int BIT_IDX_W  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // input tdata layout: channel, pixel, color from bit 0 up
  localparam int IN_CHAN_LSB  = 0;
  localparam int IN_PIXEL_LSB = IN_CHAN_LSB + CHAN_W;
  localparam int IN_COLOR_LSB = IN_PIXEL_LSB + PIXEL_W;
  localparam int IN_DATA_W    = ((IN_COLOR_LSB + COLOR_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SEND = 3'b010,
    PH_GAP  = 3'b100
  } phase_t;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_AT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH_END  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH_END   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_END        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_UPDATE    = 3'd7;

  localparam logic [TIMER_W-1:0] RST_RISE_AT       = 16'd1;
  localparam logic [TIMER_W-1:0] RST_ZERO_HIGH_END = 16'd31;
  localparam logic [TIMER_W-1:0] RST_ONE_HIGH_END  = 16'd61;
  localparam logic [TIMER_W-1:0] RST_BIT_PERIOD    = 16'd120;
  localparam logic [TIMER_W-1:0] RST_GAP_END       = 16'd8120;
  localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_PIXEL - 1);

  // pixel store write request
  typedef struct packed {
    logic               en;
    logic [CHAN_W-1:0]  channel;
    logic [PIXEL_W-1:0] pixel;
    logic [COLOR_W-1:0] color;
  } wr_req_t;

endpackage

// ===== design/wsmce_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module wsmce_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/wsmce_fetch.sv =====
// Per-channel pixel store with read-ahead of the next pixel row and write bypass.
`timescale 1ns / 1ps
module wsmce_fetch #(
  parameter int CHANNELS   = wsmce_pkg::DEF_CHANNELS,
  parameter int MAX_PIXELS = wsmce_pkg::DEF_MAX_PIXELS,
  parameter int AW         = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  wsmce_pkg::wr_req_t                         wr,
  input  logic [AW-1:0]                              rd_addr,
  output logic [CHANNELS-1:0][wsmce_pkg::COLOR_W-1:0] view
);
  import wsmce_pkg::*;

  localparam int CW1 = CHAN_W + 1;

  logic [CHANNELS-1:0][COLOR_W-1:0] rd_q;
  logic [CHANNELS-1:0]              we_vec;
  logic [CHANNELS-1:0]              hit_nxt;
  logic [CHANNELS-1:0]              hit_r;
  logic [COLOR_W-1:0]               byp_r;
  logic [AW-1:0]                    waddr;

  assign waddr = AW'(wr.pixel);

  genvar c;
  for (c = 0; c < CHANNELS; c++) begin : g_ch
    assign we_vec[c]  = wr.en && ({1'b0, wr.channel} == CW1'(c));
    // a write landing on the row being read is missed by the read port
    assign hit_nxt[c] = we_vec[c] && (waddr == rd_addr);

    wsmce_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (MAX_PIXELS),
      .AW    (AW)
    ) u_ram (
      .clk   (clk),
      .we    (we_vec[c]),
      .waddr (waddr),
      .wdata (wr.color),
      .raddr (rd_addr),
      .rdata (rd_q[c])
    );

    assign view[c] = hit_r[c] ? byp_r : rd_q[c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= '0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_r <= wr.color;
  end

endmodule

// ===== design/ws2812_multichannel_encoder_core.sv =====
// Top level of the multichannel WS2812 bit encoder.
// A request's result is registered at the output, or in the skid stage on a stall.
// Throughput: one request per cycle while out_tready is high; a skid stage keeps
// in_tready high for one stall. The pixel store reads the next pixel row ahead.
// Reset (rst_n low, synchronous): control, timing registers and lines go to defaults;
// the pixel store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`include "ws2812_multichannel_encoder_core_macros.svh"
module ws2812_multichannel_encoder_core #(
  parameter int CHANNELS   = wsmce_pkg::DEF_CHANNELS,
  parameter int MAX_PIXELS = wsmce_pkg::DEF_MAX_PIXELS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // channel[3:0], pixel[11:4], color[35:12], zero pad above
  input  logic [wsmce_pkg::IN_DATA_W-1:0]       in_tdata,
  // op[1:0]
  input  logic [wsmce_pkg::OP_W-1:0]            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // lines[CHANNELS-1:0], busy_res, frame_done, accepted, zero pad above
  output logic [((CHANNELS + 10) / 8) * 8 - 1:0] out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wsmce_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wsmce_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import wsmce_pkg::*;

  localparam int OUT_W   = ((CHANNELS + 10) / 8) * 8;
  localparam int PIX_AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int MAXP_CL = (MAX_PIXELS > 511) ? 511 : MAX_PIXELS;
  localparam int CW1     = CHAN_W + 1;

  // configuration
  logic [FLEN_W-1:0]   frame_len_r;
  logic [CHANNELS-1:0] chan_en_r;
  logic [TIMER_W-1:0]  rise_at_r;
  logic [TIMER_W-1:0]  zero_end_r;
  logic [TIMER_W-1:0]  one_end_r;
  logic [TIMER_W-1:0]  bit_period_r;
  logic [TIMER_W-1:0]  gap_end_r;
  logic                sync_r;

  // encoder state
  phase_t                           phase_r, phase_nxt;
  logic [TIMER_W-1:0]               tick_r, tick_nxt;
  logic [BIT_IDX_W-1:0]             bit_idx_r, bit_idx_nxt;
  logic [FLEN_W-1:0]                pix_idx_r, pix_idx_nxt;
  logic [CHANNELS-1:0]              lines_r, lines_nxt;
  logic [CHANNELS-1:0][COLOR_W-1:0] colors_r, colors_nxt;

  // output register and skid
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic [OUT_W-1:0] skid_data_r, skid_data_nxt;

  logic                             in_fire;
  logic                             out_fire;
  op_t                              in_op;
  logic [CHAN_W-1:0]                in_channel;
  logic [PIXEL_W-1:0]               in_pixel;
  logic [COLOR_W-1:0]               in_color;
  logic [FLEN_W-1:0]                eff_len;
  logic [TIMER_W-1:0]               tick_inc;
  logic [FLEN_W-1:0]                pix_inc;
  logic [CHANNELS-1:0]              cur_bits;
  logic                             done;
  logic                             acc;
  logic [OUT_W-1:0]                 result;
  logic [PIX_AW-1:0]                rd_addr;
  logic [CHANNELS-1:0][COLOR_W-1:0] view;
  wr_req_t                          wr_req;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !skid_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_op      = op_t'(in_tuser);
  assign in_channel = in_tdata[IN_CHAN_LSB +: CHAN_W];
  assign in_pixel   = in_tdata[IN_PIXEL_LSB +: PIXEL_W];
  assign in_color   = in_tdata[IN_COLOR_LSB +: COLOR_W];

  assign eff_len  = (frame_len_r > FLEN_W'(MAXP_CL)) ? FLEN_W'(MAXP_CL) : frame_len_r;
  assign tick_inc = tick_r + 1'b1;
  assign pix_inc  = pix_idx_r + 1'b1;

  // row of the next pixel while sending, pixel 0 otherwise (ready for a start)
  assign rd_addr = (phase_r == PH_SEND) ? PIX_AW'(pix_inc) : '0;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_bit
    assign cur_bits[c] = colors_r[c][bit_idx_r];
  end

  wsmce_fetch #(
    .CHANNELS   (CHANNELS),
    .MAX_PIXELS (MAX_PIXELS),
    .AW         (PIX_AW)
  ) u_fetch (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr_req),
    .rd_addr (rd_addr),
    .view    (view)
  );

  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    bit_idx_nxt = bit_idx_r;
    pix_idx_nxt = pix_idx_r;
    lines_nxt   = lines_r;
    colors_nxt  = colors_r;
    done        = 1'b0;
    acc         = 1'b0;
    wr_req.en      = 1'b0;
    wr_req.channel = in_channel;
    wr_req.pixel   = in_pixel;
    wr_req.color   = in_color;

    if (in_fire) begin
      case (in_op)
        OP_WRITE: begin
          if (({1'b0, in_channel} < CW1'(CHANNELS)) && ({1'b0, in_pixel} < eff_len) &&
              !(sync_r && (phase_r != PH_IDLE))) begin
            wr_req.en = 1'b1;
            acc       = 1'b1;
          end
        end
        OP_START: begin
          if (phase_r == PH_IDLE) begin
            acc         = 1'b1;
            pix_idx_nxt = '0;
            lines_nxt   = '0;
            tick_nxt    = '0;
            if (eff_len != '0) begin
              colors_nxt  = view;
              bit_idx_nxt = LAST_BIT;
              phase_nxt   = PH_SEND;
            end else begin
              phase_nxt = PH_GAP;
            end
          end
        end
        OP_TICK: begin
          case (phase_r)
            PH_SEND: begin
              tick_nxt = tick_inc;
              // rise, then falls, then bit end: a fall on the rise count wins
              if (tick_inc == rise_at_r) begin
                lines_nxt = lines_nxt | chan_en_r;
              end
              if (tick_inc == zero_end_r) begin
                lines_nxt = lines_nxt & cur_bits;
              end
              if (tick_inc == one_end_r) begin
                lines_nxt = '0;
              end
              if (tick_inc == bit_period_r) begin
                if (bit_idx_r != '0) begin
                  bit_idx_nxt = bit_idx_r - 1'b1;
                  tick_nxt    = '0;
                end else begin
                  lines_nxt   = '0;
                  pix_idx_nxt = pix_inc;
                  if (pix_inc < eff_len) begin
                    colors_nxt  = view;
                    bit_idx_nxt = LAST_BIT;
                    tick_nxt    = '0;
                  end else begin
                    phase_nxt = PH_GAP;
                  end
                end
              end
            end
            PH_GAP: begin
              lines_nxt = '0;
              tick_nxt  = tick_inc;
              if (tick_inc == gap_end_r) begin
                phase_nxt = PH_IDLE;
                tick_nxt  = '0;
                done      = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assign result = OUT_W'({acc, done, (phase_nxt != PH_IDLE), lines_nxt});

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_fire || !out_valid_r) begin
      out_valid_nxt  = skid_valid_r || in_fire;
      out_data_nxt   = skid_valid_r ? skid_data_r : result;
      skid_valid_nxt = 1'b0;
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r  <= '0;
      chan_en_r    <= '1;
      rise_at_r    <= RST_RISE_AT;
      zero_end_r   <= RST_ZERO_HIGH_END;
      one_end_r    <= RST_ONE_HIGH_END;
      bit_period_r <= RST_BIT_PERIOD;
      gap_end_r    <= RST_GAP_END;
      sync_r       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_LENGTH:   frame_len_r  <= cfg_data[FLEN_W-1:0];
        REG_CHANNEL_ENABLE: chan_en_r    <= cfg_data[CHANNELS-1:0];
        REG_RISE_AT:        rise_at_r    <= cfg_data;
        REG_ZERO_HIGH_END:  zero_end_r   <= cfg_data;
        REG_ONE_HIGH_END:   one_end_r    <= cfg_data;
        REG_BIT_PERIOD:     bit_period_r <= cfg_data;
        REG_GAP_END:        gap_end_r    <= cfg_data;
        REG_SYNC_UPDATE:    sync_r       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_r       <= '0;
      bit_idx_r    <= LAST_BIT;
      pix_idx_r    <= '0;
      lines_r      <= '0;
      colors_r     <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      tick_r       <= tick_nxt;
      bit_idx_r    <= bit_idx_nxt;
      pix_idx_r    <= pix_idx_nxt;
      lines_r      <= lines_nxt;
      colors_r     <= colors_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `WSMCE_ASSERT(a_skid_out, skid_valid_r |-> out_valid_r, "skid without output")
  `WSMCE_ASSERT(a_lines_low, (phase_r != PH_SEND) |-> (lines_r == '0), "line high off send")
  `WSMCE_ASSERT_NEXT(a_skid_in, out_valid_r && !out_tready && in_fire, skid_valid_r, "no skid")

endmodule
